@@ hw/rtl/s2l_pkg.sv @@
// ----------------------------------------------------------------------------
// s2l_pkg: shared constants and helpers for the sRGB to CIELAB converter
// Holds the linearization table, matrix constants, widths and the
// reciprocals used by the constant-divide stages.
// ----------------------------------------------------------------------------
package s2l_pkg;

  // Q1.31 unit value
  localparam int QFrac = 31;

  // Cube-root search: one candidate bit per iteration, two stages each
  localparam int CbrtIter   = 31;
  localparam int CbrtStages = 2 * CbrtIter + 1;

  // Constant dividers: reciprocal product, back-multiply, remainder fix-up
  localparam int DivStages = 3;

  // lookup, products, sum, XYZ divide, f() setup, f() divide, cube root, out x2
  localparam int PipeDepth = 3 + DivStages + 1 + DivStages + CbrtStages + 2;

  // sRGB -> XYZ rows, each scaled so the row divider normalizes by white
  localparam logic [0:2][0:2][23:0] MatCoef = {
    24'd4124564, 24'd3575761, 24'd1804375,
    24'd2126729, 24'd7151522, 24'd721750,
    24'd193339,  24'd1191920, 24'd9503041
  };
  localparam logic [0:2][23:0] MatDiv  = {24'd9504700, 24'd10000000, 24'd10888300};
  localparam logic [0:2][23:0] MatHalf = {24'd4752350, 24'd5000000,  24'd5444150};

  // floor(2^55 / divider): quotient estimate from numerator bits [54:23]
  localparam logic [0:2][31:0] MatRecip = {
    32'((64'd1 << 55) / 64'(MatDiv[0])),
    32'((64'd1 << 55) / 64'(MatDiv[1])),
    32'((64'd1 << 55) / 64'(MatDiv[2]))
  };

  // Lab linear segment: (24389 w + 432*2^31 + 1566) / 3132
  localparam logic [23:0] LabDiv = 24'd3132;

  // floor(2^43 / 3132): quotient estimate from numerator bits [41:10]
  localparam logic [31:0] LabRecip = 32'((64'd1 << 43) / 64'(LabDiv));

  typedef logic [255:0][31:0] lin_tbl_t;

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> QFrac;
  endfunction

  function automatic logic [63:0] pow5(logic [63:0] x);
    logic [63:0] s;
    s = qmul(x, x);
    s = qmul(s, x);
    s = qmul(s, x);
    return qmul(s, x);
  endfunction

  // sRGB byte -> linear Q1.31, evaluated at elaboration
  function automatic lin_tbl_t build_lin_tbl();
    lin_tbl_t    tbl;
    logic [63:0] t, t2, lo, hi, mid, lin, vv;
    for (int v = 0; v < 256; v++) begin
      vv = 64'(v);
      if (vv * 64'd100000 <= 64'd1031475) begin
        lin = (vv * 64'd100 * (64'd1 << QFrac) + 64'd164730) / 64'd329460;
      end else begin
        t  = ((64'd1000 * vv + 64'd14025) * (64'd1 << QFrac) + 64'd134512) / 64'd269025;
        t2 = qmul(t, t);
        lo = 64'd0;
        hi = 64'd1 << QFrac;
        for (int i = 0; i < 33; i++) begin
          if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (pow5(mid) <= t2) begin
              lo = mid;
            end else begin
              hi = mid - 64'd1;
            end
          end
        end
        lin = qmul(t2, lo);
      end
      tbl[v] = lin[31:0];
    end
    return tbl;
  endfunction

  localparam lin_tbl_t LinTbl = build_lin_tbl();

endpackage

@@ hw/rtl/s2l_cbrt.sv @@
// ----------------------------------------------------------------------------
// s2l_cbrt: pipelined Lab curve for one channel
// Bitwise cube-root search in Q1.31, one candidate bit per two stages,
// selects the precomputed linear segment below the threshold.
// ----------------------------------------------------------------------------
module s2l_cbrt import s2l_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] w_i,
  input  logic [31:0] lin_i,
  input  logic        sel_i,
  output logic [31:0] f_o
);

  logic [CbrtIter-1:0][30:0] sq_q, ca_q, cb_q;
  logic [CbrtIter-1:0][31:0] wa_q, la_q, wb_q, lb_q;
  logic [CbrtIter-1:0]       sa_q, sb_q;
  logic [31:0]               f_q;

  for (genvar i = 0; i < CbrtIter; i++) begin : g_it
    localparam logic [30:0] BitMask = 31'(1) << (CbrtIter - 1 - i);

    logic [30:0] c_in, cand;
    logic [31:0] w_in, l_in;
    logic        s_in;
    logic [61:0] sq_full, cube_full;

    if (i == 0) begin : g_first
      assign c_in = '0;
      assign w_in = w_i;
      assign l_in = lin_i;
      assign s_in = sel_i;
    end else begin : g_next
      assign c_in = cb_q[i-1];
      assign w_in = wb_q[i-1];
      assign l_in = lb_q[i-1];
      assign s_in = sb_q[i-1];
    end

    assign cand      = c_in | BitMask;
    assign sq_full   = 62'(cand) * 62'(cand);
    assign cube_full = 62'(sq_q[i]) * 62'(ca_q[i]);

    // square of the candidate
    always_ff @(posedge clk_i) begin
      sq_q[i] <= sq_full[61:31];
      ca_q[i] <= cand;
      wa_q[i] <= w_in;
      la_q[i] <= l_in;
      sa_q[i] <= s_in;
    end

    // cube and keep the bit if it does not overshoot
    always_ff @(posedge clk_i) begin
      cb_q[i] <= ({1'b0, cube_full[61:31]} <= wa_q[i]) ? ca_q[i] : (ca_q[i] & ~BitMask);
      wb_q[i] <= wa_q[i];
      lb_q[i] <= la_q[i];
      sb_q[i] <= sa_q[i];
    end
  end

  // w at full scale only occurs as exactly 1.0, whose root is 1.0
  always_ff @(posedge clk_i) begin
    if (sb_q[CbrtIter-1]) begin
      f_q <= wb_q[CbrtIter-1][31] ? 32'h8000_0000 : {1'b0, cb_q[CbrtIter-1]};
    end else begin
      f_q <= lb_q[CbrtIter-1];
    end
  end

  assign f_o = f_q;

endmodule

@@ hw/rtl/srgb_to_cielab.sv @@
// ----------------------------------------------------------------------------
// srgb_to_cielab: 8-bit sRGB pixel to CIELAB (D65), Q7.8 and Q8.8 outputs
// Fully pipelined converter, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//  - Input word: red_i, green_i, blue_i, taken on a clock edge with start_i
//    high and busy_o low. busy_o is always low: a new word can enter every
//    cycle, so the throughput is one pixel per clock.
//  - Result word: lightness_o (L*, unsigned Q7.8), green_red_o (a*) and
//    blue_yellow_o (b*) (signed Q8.8, saturated), shown for one cycle with
//    done_o high.
//  - The pipe is PipeDepth stages deep, with done_o as its last valid bit;
//    its depth comes mostly from the cube-root search (two stages per root
//    bit, 31 bits) plus two 3-stage constant dividers.
//  - Results leave in input order. The receiver cannot stall, so there is
//    no backpressure anywhere in the pipe; data registers run freely and
//    only the valid bits mark live words.
//  - Reset clears the valid bits only; no word is lost mid-pipe except
//    those in flight at reset. There is no configuration and no state.
// ----------------------------------------------------------------------------
module srgb_to_cielab import s2l_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [14:0]        lightness_o,
  output logic signed [15:0] green_red_o,
  output logic signed [15:0] blue_yellow_o
);

  // divide by 2^23, round half away from zero
  function automatic logic signed [19:0] rnd_q88(logic signed [41:0] v);
    logic [41:0] m;
    logic [41:0] r;
    m = v[41] ? 42'(-v) : 42'(v);
    r = (m + (42'd1 << 22)) >> 23;
    return v[41] ? -$signed(r[19:0]) : $signed(r[19:0]);
  endfunction

  logic [PipeDepth-1:0] vld_q;

  logic [2:0][31:0]       lin_q;
  logic [2:0][2:0][55:0]  prod_q;
  logic [2:0][55:0]       num_q;

  logic [2:0][63:0] xprod;
  logic [2:0][55:0] xqd_full;
  logic [2:0][31:0] xp_q, xq0_q, xyz_q;
  logic [2:0][25:0] xn1_q, xn2_q, xqd_q, xr;

  logic [2:0][31:0] ew_q;
  logic [2:0]       esel_q;
  logic [2:0][45:0] elnum_q;
  logic [2:0][45:0] eprod;

  logic [2:0][63:0] lprod;
  logic [2:0][55:0] lqd_full;
  logic [2:0][30:0] lp_q;
  logic [2:0][31:0] lq0_q, labl_q;
  logic [2:0][13:0] ln1_q, ln2_q, lqd_q, lr;
  logic [DivStages-1:0][2:0][31:0] gw_q;
  logic [DivStages-1:0][2:0]       gsel_q;

  logic [2:0][31:0]  f;
  logic signed [41:0] lm_q, am_q, bm_q;
  logic signed [32:0] fx_s, fy_s, fz_s;
  logic signed [19:0] l_r, a_r, b_r;

  logic [14:0]        light_q;
  logic signed [15:0] gr_q, by_q;

  // valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], start_i};
    end
  end

  // byte -> linear Q1.31
  always_ff @(posedge clk_i) begin
    lin_q[0] <= LinTbl[red_i];
    lin_q[1] <= LinTbl[green_i];
    lin_q[2] <= LinTbl[blue_i];
  end

  // matrix products, then row sums with rounding offset
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= 56'(lin_q[c]) * 56'(MatCoef[r][c]);
      end
      num_q[r] <= prod_q[r][0] + prod_q[r][1] + prod_q[r][2] + 56'(MatHalf[r]);
    end
  end

  // XYZ = row sum / row divider. Sum < 2^55; the reciprocal estimate is
  // at most two below the quotient, and the remainder fits 26 bits.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      xprod[r]    = 64'(num_q[r][54:23]) * 64'(MatRecip[r]);
      xqd_full[r] = 56'(xp_q[r]) * 56'(MatDiv[r]);
      xr[r]       = xn2_q[r] - xqd_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      xp_q[r]  <= xprod[r][63:32];
      xn1_q[r] <= num_q[r][25:0];
      xq0_q[r] <= xp_q[r];
      xqd_q[r] <= xqd_full[r][25:0];
      xn2_q[r] <= xn1_q[r];
      if (xr[r] >= (26'(MatDiv[r]) << 1)) begin
        xyz_q[r] <= xq0_q[r] + 32'd2;
      end else if (xr[r] >= 26'(MatDiv[r])) begin
        xyz_q[r] <= xq0_q[r] + 32'd1;
      end else begin
        xyz_q[r] <= xq0_q[r];
      end
    end
  end

  // Lab curve setup: threshold test and linear-segment numerator
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      eprod[r] = 46'(xyz_q[r]) * 46'd24389;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      ew_q[r]    <= xyz_q[r];
      esel_q[r]  <= eprod[r] > (46'd216 << QFrac);
      elnum_q[r] <= eprod[r] + (46'd432 << QFrac) + 46'd1566;
    end
  end

  // linear segment divide by 3132; result only used below the threshold,
  // where the numerator is below 2^41 and the estimate is at most one low
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lprod[r]    = 64'(elnum_q[r][41:10]) * 64'(LabRecip);
      lqd_full[r] = 56'(lp_q[r]) * 56'(LabDiv);
      lr[r]       = ln2_q[r] - lqd_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      lp_q[r]   <= lprod[r][63:33];
      ln1_q[r]  <= elnum_q[r][13:0];
      lq0_q[r]  <= {1'b0, lp_q[r]};
      lqd_q[r]  <= lqd_full[r][13:0];
      ln2_q[r]  <= ln1_q[r];
      labl_q[r] <= (lr[r] >= 14'(LabDiv)) ? lq0_q[r] + 32'd1 : lq0_q[r];
    end
    gw_q[0]   <= ew_q;
    gsel_q[0] <= esel_q;
    for (int j = 1; j < DivStages; j++) begin
      gw_q[j]   <= gw_q[j-1];
      gsel_q[j] <= gsel_q[j-1];
    end
  end

  // cube-root pipes, one per channel
  for (genvar r = 0; r < 3; r++) begin : g_lab
    s2l_cbrt u_cbrt (
      .clk_i (clk_i),
      .w_i   (gw_q[DivStages-1][r]),
      .lin_i (labl_q[r]),
      .sel_i (gsel_q[DivStages-1][r]),
      .f_o   (f[r])
    );
  end

  assign fx_s = $signed({1'b0, f[0]});
  assign fy_s = $signed({1'b0, f[1]});
  assign fz_s = $signed({1'b0, f[2]});

  // L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz), all Q31
  always_ff @(posedge clk_i) begin
    lm_q <= 42'(fy_s) * 42'sd116 - (42'sd16 <<< QFrac);
    am_q <= 42'(fx_s - fy_s) * 42'sd500;
    bm_q <= 42'(fy_s - fz_s) * 42'sd200;
  end

  assign l_r = rnd_q88(lm_q);
  assign a_r = rnd_q88(am_q);
  assign b_r = rnd_q88(bm_q);

  // round to Q7.8 (L*) and Q8.8 (a*, b*) and saturate
  always_ff @(posedge clk_i) begin
    if (l_r < 20'sd0) begin
      light_q <= '0;
    end else if (l_r > 20'sd25600) begin
      light_q <= 15'd25600;
    end else begin
      light_q <= l_r[14:0];
    end

    if (a_r < -20'sd32768) begin
      gr_q <= 16'sh8000;
    end else if (a_r > 20'sd32767) begin
      gr_q <= 16'sd32767;
    end else begin
      gr_q <= a_r[15:0];
    end

    if (b_r < -20'sd32768) begin
      by_q <= 16'sh8000;
    end else if (b_r > 20'sd32767) begin
      by_q <= 16'sd32767;
    end else begin
      by_q <= b_r[15:0];
    end
  end

  assign busy_o        = 1'b0;
  assign done_o        = vld_q[PipeDepth-1];
  assign lightness_o   = light_q;
  assign green_red_o   = gr_q;
  assign blue_yellow_o = by_q;

endmodule
